@@ rtl/core/pcbs_pkg.sv @@
// ----------------------------------------------------------------------------
// pcbs_pkg: shared types and constants for path cost best select
// Widths, CORDIC angle table and the front-to-back transaction type.
// ----------------------------------------------------------------------------
package pcbs_pkg;

   localparam int MAX_PATHS_DEF    = 1024;
   localparam int COORD_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int WEIGHT_W   = 17;
   localparam int IDX_W      = 10;
   localparam int LEN_OUT_W  = 27;
   localparam int LEN_SUM_W  = 36;
   localparam int ANG_W      = 23;
   localparam int SCORE_W    = 57;
   localparam int DIFF_W     = 24;   // |d| of up to 23-bit coordinates
   localparam int SQ_W       = 64;   // radicand (ax^2+ay^2) << 16
   localparam int ROOT_W     = 32;
   localparam int CORD_W     = 48;   // signed CORDIC datapath
   localparam int Z_W        = 20;

   localparam logic [ANG_W-1:0] HALF_PI_Q12 = ANG_W'(6434);

   // register index, taken from paddr[2]
   localparam logic [0:0] CSR_LENGTH_WEIGHT = 1'd0;
   localparam logic [0:0] CSR_ANGLE_WEIGHT  = 1'd1;

   // Q.16 arctangent table
   function automatic logic [Z_W-1:0] atan_q16(input logic [4:0] i);
      logic [Z_W-1:0] r;
      unique case (i)
         5'd0:  r = Z_W'(51472);
         5'd1:  r = Z_W'(30385);
         5'd2:  r = Z_W'(16055);
         5'd3:  r = Z_W'(8150);
         5'd4:  r = Z_W'(4091);
         5'd5:  r = Z_W'(2047);
         5'd6:  r = Z_W'(1024);
         5'd7:  r = Z_W'(512);
         5'd8:  r = Z_W'(256);
         5'd9:  r = Z_W'(128);
         5'd10: r = Z_W'(64);
         5'd11: r = Z_W'(32);
         5'd12: r = Z_W'(16);
         5'd13: r = Z_W'(8);
         5'd14: r = Z_W'(4);
         5'd15: r = Z_W'(2);
         5'd16: r = Z_W'(1);
         5'd17: r = Z_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // transaction handed from front to back
   typedef struct packed {
      logic [DIFF_W-1:0] ax;
      logic [DIFF_W-1:0] ay;
      logic              do_len;     // second or later point
      logic              do_ang;     // third or later point
      logic              end_path;
      logic              end_set;
   } seg_type;

endpackage

@@ rtl/core/pcbs_front.sv @@
// ----------------------------------------------------------------------------
// pcbs_front: point intake
// Keeps the previous point, forms |dx|, |dy| and classifies the point.
// ----------------------------------------------------------------------------
module pcbs_front
   import pcbs_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic [15:0]           in_x,
   input  logic [15:0]           in_y,
   input  logic                  in_last_path,
   input  logic                  in_last_set,
   output logic                  out_valid,
   input  logic                  out_stall,
   output seg_type               out_seg
);
   localparam int CW = (COORD_BITS > 23) ? 23 : ((COORD_BITS < 4) ? 4 : COORD_BITS);

   logic signed [DIFF_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [1:0]               seen_ff, seen_in;
   logic                     vld_ff, vld_in;
   seg_type                  seg_ff, seg_in;
   logic [DIFF_W-1:0]        zx, zy;
   logic signed [DIFF_W-1:0] sx, sy, dx, dy;
   logic                     take;

   assign in_stall  = vld_ff && out_stall;
   assign take      = in_valid && !in_stall;
   assign out_valid = vld_ff;
   assign out_seg   = seg_ff;

   always_comb begin
      // field bits above 16 read as zero when the coordinate is wider
      zx = DIFF_W'(in_x);
      zy = DIFF_W'(in_y);
      sx = DIFF_W'(signed'(zx[CW-1:0]));
      sy = DIFF_W'(signed'(zy[CW-1:0]));
      dx = sx - prev_x_ff;
      dy = sy - prev_y_ff;
      seg_in = seg_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      seen_in = seen_ff;
      vld_in = vld_ff && out_stall;
      if (take) begin
         seg_in.ax = dx[DIFF_W-1] ? -dx : dx;
         seg_in.ay = dy[DIFF_W-1] ? -dy : dy;
         seg_in.do_len = (seen_ff != 2'd0);
         seg_in.do_ang = (seen_ff == 2'd2);
         seg_in.end_path = in_last_path;
         seg_in.end_set = in_last_set;
         prev_x_in = sx;
         prev_y_in = sy;
         if (in_last_path) seen_in = 2'd0;
         else if (seen_ff != 2'd2) seen_in = seen_ff + 2'd1;
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         seen_ff   <= '0;
         vld_ff    <= 1'b0;
      end else begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         seen_ff   <= seen_in;
         vld_ff    <= vld_in;
      end
      seg_ff <= seg_in;
   end
endmodule

@@ rtl/core/pcbs_queue.sv @@
// ----------------------------------------------------------------------------
// pcbs_queue: two-entry queue between front and back
// Lets either side stall independently.
// ----------------------------------------------------------------------------
module pcbs_queue
   import pcbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  seg_type in_seg,
   output logic    out_valid,
   input  logic    out_stall,
   output seg_type out_seg
);
   seg_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_seg   = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_seg;
   end
endmodule

@@ rtl/core/pcbs_back.sv @@
// ----------------------------------------------------------------------------
// pcbs_back: segment evaluation, path totals and best selection
// Sequencer over a bit-serial square root, a CORDIC unit and a score multiply.
// ----------------------------------------------------------------------------
module pcbs_back
   import pcbs_pkg::*;
#(
   parameter int MAX_PATHS    = MAX_PATHS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  seg_type               in_seg,
   input  logic [WEIGHT_W-1:0]   len_weight,
   input  logic [WEIGHT_W-1:0]   ang_weight,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [IDX_W-1:0]      out_index,
   output logic [LEN_OUT_W-1:0]  out_length,
   output logic [ANG_W-1:0]      out_angle,
   output logic [IDX_W-1:0]      out_best,
   output logic                  out_done,
   output logic                  out_sat
);
   localparam int NSTEPS   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int PATH_CAP = (MAX_PATHS > 1024) ? 1024 : ((MAX_PATHS < 1) ? 1 : MAX_PATHS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PATH_CAP - 1);
   localparam logic [LEN_SUM_W:0] LEN_SUM_MAX = {1'b0, {LEN_SUM_W{1'b1}}};

   typedef enum logic [2:0] {
      S_IDLE, S_SQRT, S_MUL1, S_MUL2, S_CMP, S_OUT
   } state_type;

   state_type               state_ff;
   seg_type                 seg_ff;
   logic [5:0]              step_ff;
   // square root: 32 iterations, one result bit each
   logic [SQ_W-1:0]         rad_ff;
   logic [ROOT_W+1:0]       rem_ff;
   logic [ROOT_W-1:0]       root_ff;
   // CORDIC runs in parallel with the root
   logic signed [CORD_W-1:0] cx_ff, cy_ff;
   logic signed [Z_W:0]     cz_ff;
   logic                    cord_on_ff;
   logic [LEN_SUM_W-1:0]    len_sum_ff;
   logic [ANG_W-1:0]        ang_sum_ff;
   logic                    psat_ff, full_ff;
   logic [IDX_W-1:0]        cnt_ff, best_ff;
   logic [SCORE_W-1:0]      best_score_ff;
   logic                    have_best_ff;
   logic [LEN_OUT_W-1:0]    len_ff;
   logic [SCORE_W-1:0]      prod_l_ff, prod_a_ff;
   logic                    ovalid_ff;
   logic [IDX_W-1:0]        o_idx_ff, o_best_ff;
   logic [LEN_OUT_W-1:0]    o_len_ff;
   logic [ANG_W-1:0]        o_ang_ff;
   logic                    o_done_ff, o_sat_ff;

   logic [ROOT_W+1:0]       trial;
   logic [ROOT_W+1:0]       rem_sh;
   logic signed [CORD_W-1:0] xs, ys;
   logic [LEN_SUM_W:0]      len_acc;
   logic [ANG_W:0]          ang_acc;
   logic [Z_W:0]            zq;
   logic [ANG_W-1:0]        seg_ang;
   logic [LEN_SUM_W:0]      len_rnd;
   logic [SCORE_W-1:0]      score;
   logic [2*DIFF_W-1:0]     sq_x, sq_y;
   logic [2*DIFF_W:0]       sumsq;
   logic [WEIGHT_W+LEN_OUT_W-1:0] mul_l;
   logic [WEIGHT_W+ANG_W-1:0]     mul_a;

   assign in_stall  = (state_ff != S_IDLE);
   assign out_valid = ovalid_ff;
   assign out_index = o_idx_ff;
   assign out_length = o_len_ff;
   assign out_angle = o_ang_ff;
   assign out_best  = o_best_ff;
   assign out_done  = o_done_ff;
   assign out_sat   = o_sat_ff;

   always_comb begin
      rem_sh = {rem_ff[ROOT_W-1:0], rad_ff[SQ_W-1 -: 2]};
      trial  = rem_sh - {root_ff, 2'b01};
      xs = cx_ff >>> step_ff[4:0];
      ys = cy_ff >>> step_ff[4:0];
      zq = '0;
      // final angle of this segment
      if (seg_ff.ax == '0) seg_ang = HALF_PI_Q12;
      else if (seg_ff.ay == '0) seg_ang = '0;
      else begin
         zq = cz_ff[Z_W] ? '0 : (Z_W+1)'((cz_ff + (Z_W+1)'(8)) >>> 4);
         seg_ang = ((ANG_W)'(zq) > HALF_PI_Q12) ? HALF_PI_Q12 : ANG_W'(zq);
      end
      len_acc = {1'b0, len_sum_ff} + (LEN_SUM_W+1)'(root_ff);
      ang_acc = {1'b0, ang_sum_ff} + {1'b0, seg_ang};
      len_rnd = ({1'b0, len_sum_ff} + (LEN_SUM_W+1)'(128)) >> 8;
      score   = prod_l_ff + prod_a_ff;
      sq_x    = in_seg.ax * in_seg.ax;
      sq_y    = in_seg.ay * in_seg.ay;
      sumsq   = {1'b0, sq_x} + {1'b0, sq_y};
      mul_l   = len_weight * len_ff;
      mul_a   = ang_weight * ang_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_sum_ff <= '0;
         ang_sum_ff <= '0;
         psat_ff <= 1'b0;
         full_ff <= 1'b0;
         cnt_ff <= '0;
         best_ff <= '0;
         best_score_ff <= '0;
         have_best_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (ovalid_ff && !out_stall && state_ff != S_OUT) ovalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  seg_ff <= in_seg;
                  rad_ff <= SQ_W'(sumsq) << 16;
                  rem_ff <= '0;
                  root_ff <= '0;
                  step_ff <= '0;
                  cx_ff <= CORD_W'(in_seg.ax) <<< 16;
                  cy_ff <= CORD_W'(in_seg.ay) <<< 16;
                  cz_ff <= '0;
                  cord_on_ff <= 1'b1;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               rad_ff <= rad_ff << 2;
               if (!trial[ROOT_W+1]) begin
                  rem_ff <= trial;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
               end
               if (cord_on_ff && step_ff < 6'(NSTEPS)) begin
                  if (!cy_ff[CORD_W-1]) begin
                     cx_ff <= cx_ff + ys;
                     cy_ff <= cy_ff - xs;
                     cz_ff <= cz_ff + (Z_W+1)'(atan_q16(step_ff[4:0]));
                  end else begin
                     cx_ff <= cx_ff - ys;
                     cy_ff <= cy_ff + xs;
                     cz_ff <= cz_ff - (Z_W+1)'(atan_q16(step_ff[4:0]));
                  end
               end
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'(ROOT_W - 1)) state_ff <= S_MUL1;
            end
            S_MUL1: begin
               // accumulate this segment
               if (seg_ff.do_len) begin
                  if (len_acc > LEN_SUM_MAX) len_sum_ff <= LEN_SUM_MAX[LEN_SUM_W-1:0];
                  else len_sum_ff <= len_acc[LEN_SUM_W-1:0];
               end
               if (seg_ff.do_ang) begin
                  if (ang_acc[ANG_W]) ang_sum_ff <= '1;
                  else ang_sum_ff <= ang_acc[ANG_W-1:0];
               end
               if ((seg_ff.do_len && len_acc > LEN_SUM_MAX) ||
                   (seg_ff.do_ang && ang_acc[ANG_W])) psat_ff <= 1'b1;
               state_ff <= seg_ff.end_path ? S_MUL2 : S_IDLE;
            end
            S_MUL2: begin
               if (len_rnd > (LEN_SUM_W+1)'({LEN_OUT_W{1'b1}})) begin
                  len_ff <= '1;
                  psat_ff <= 1'b1;
               end else len_ff <= len_rnd[LEN_OUT_W-1:0];
               state_ff <= S_CMP;
            end
            S_CMP: begin
               prod_l_ff <= SCORE_W'({mul_l, 12'b0});
               prod_a_ff <= SCORE_W'(mul_a);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!ovalid_ff || !out_stall) begin
                  o_idx_ff <= cnt_ff;
                  o_len_ff <= len_ff;
                  o_ang_ff <= ang_sum_ff;
                  o_done_ff <= seg_ff.end_set;
                  o_sat_ff <= psat_ff || full_ff;
                  if (!have_best_ff || score < best_score_ff) o_best_ff <= cnt_ff;
                  else o_best_ff <= best_ff;
                  ovalid_ff <= 1'b1;
                  len_sum_ff <= '0;
                  ang_sum_ff <= '0;
                  psat_ff <= 1'b0;
                  if (seg_ff.end_set) begin
                     cnt_ff <= '0;
                     best_ff <= '0;
                     best_score_ff <= '0;
                     have_best_ff <= 1'b0;
                     full_ff <= 1'b0;
                  end else begin
                     if (!have_best_ff || score < best_score_ff) begin
                        best_ff <= cnt_ff;
                        best_score_ff <= score;
                        have_best_ff <= 1'b1;
                     end
                     if (cnt_ff >= LAST_IDX) full_ff <= 1'b1;
                     else cnt_ff <= cnt_ff + IDX_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/core/path_cost_best_select.sv @@
// Back end: each point runs through a 32-step bit-serial root, with the CORDIC
//   run alongside it; a path end then adds rounding, scoring and output states.
// The back end takes no new point until it has finished the last one.
// Reset: synchronous, active high; clears previous point, sums, counters and
//   best selection; weights return to 32768.
// ----------------------------------------------------------------------------
// path_cost_best_select: lowest cost path picker
// Sums segment lengths and angles per path and tracks the best scoring path.
// ----------------------------------------------------------------------------
module path_cost_best_select
   import pcbs_pkg::*;
#(
   parameter int MAX_PATHS    = MAX_PATHS_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [15:0]   req_point_x,
   input  logic signed [15:0]   req_point_y,
   input  logic                 req_last_of_path,
   input  logic                 req_last_of_set,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IDX_W-1:0]     rsp_path_index,
   output logic [LEN_OUT_W-1:0] rsp_path_length,
   output logic [ANG_W-1:0]     rsp_path_angle,
   output logic [IDX_W-1:0]     rsp_best_index,
   output logic                 rsp_set_done,
   output logic                 rsp_saturated,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   logic [WEIGHT_W-1:0] len_w_ff, ang_w_ff;
   logic    f_valid, f_stall, b_valid, b_stall;
   seg_type f_seg, b_seg;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_w_ff <= WEIGHT_W'(32768);
         ang_w_ff <= WEIGHT_W'(32768);
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == CSR_LENGTH_WEIGHT) len_w_ff <= pwdata[WEIGHT_W-1:0];
         else if (paddr[2] == CSR_ANGLE_WEIGHT) ang_w_ff <= pwdata[WEIGHT_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == CSR_LENGTH_WEIGHT) prdata = 32'(len_w_ff);
      else if (paddr[2] == CSR_ANGLE_WEIGHT) prdata = 32'(ang_w_ff);
      else prdata = '0;
   end

   pcbs_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall),
      .in_x(req_point_x), .in_y(req_point_y),
      .in_last_path(req_last_of_path), .in_last_set(req_last_of_set),
      .out_valid(f_valid), .out_stall(f_stall), .out_seg(f_seg)
   );

   pcbs_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_seg(f_seg),
      .out_valid(b_valid), .out_stall(b_stall), .out_seg(b_seg)
   );

   pcbs_back #(.MAX_PATHS(MAX_PATHS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_stall(b_stall), .in_seg(b_seg),
      .len_weight(len_w_ff), .ang_weight(ang_w_ff),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_index(rsp_path_index), .out_length(rsp_path_length),
      .out_angle(rsp_path_angle), .out_best(rsp_best_index),
      .out_done(rsp_set_done), .out_sat(rsp_saturated)
   );
endmodule
